FILE: design/utf32_to_utf8_encoder_macros.svh
// assertion helpers for the utf-8 encoder
`ifndef UTF32_TO_UTF8_ENCODER_MACROS_SVH
`define UTF32_TO_UTF8_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// check that is skipped while reset is applied
`define U8E_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8enc check failed");
// check that also holds across reset
`define U8E_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("u8enc check failed");
`else
`define U8E_ASSERT(lbl, clk, rst_n, prop)
`define U8E_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: design/u8enc_pkg.sv
`default_nettype none

package u8enc_pkg;

    // field widths
    localparam int CP_W        = 32;
    localparam int BYTE_W      = 8;
    localparam int MAX_CP_W    = 21;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ESCAPE_BASE    = 2'd0,
        CFG_MAX_CODE_POINT = 2'd1
    } t_cfg_reg;

    // register reset values
    localparam logic [CP_W-1:0]     ESCAPE_BASE_RST = 32'h0000_DC00;
    localparam logic [MAX_CP_W-1:0] MAX_CP_RST      = 21'h10_FFFF;

    // utf-8 marker bytes
    localparam logic [BYTE_W-1:0] LEAD2     = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD3     = 8'hE0;
    localparam logic [BYTE_W-1:0] LEAD4     = 8'hF0;
    localparam logic [BYTE_W-1:0] CONT_MARK = 8'h80;

endpackage

`default_nettype wire

FILE: design/u8enc_ifs.sv
`default_nettype none

// code point channel
interface u8enc_cp_if;
    logic                         valid;
    logic                         ready;
    logic [u8enc_pkg::CP_W-1:0]   code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

// byte result channel
interface u8enc_byte_if;
    logic                         valid;
    logic                         ready;
    logic [u8enc_pkg::BYTE_W-1:0] out_byte;
    logic                         last_of_run;
    logic                         is_escape;

    modport source (output valid, output out_byte, output last_of_run,
                    output is_escape, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input is_escape, output ready);
endinterface

// register write channel
interface u8enc_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [u8enc_pkg::CFG_IDX_W-1:0]  index;
    logic [u8enc_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/utf32_to_utf8_encoder.sv
// channel   dir  payload                               item
// i_cp      in   code_point[31:0]                      one code point
// o_byte    out  out_byte[7:0], last_of_run, is_escape one output byte
// i_cfg     in   index[1:0], data[31:0]                one register write
//
// An accepted code point waits in the input register, is encoded into a
// four byte buffer, then leaves one byte per cycle from that buffer while
// o_byte.ready is high. An item takes 1 to 4 bytes of output bandwidth, set
// by its byte count; the byte buffer is the limit. Points that give no byte
// leave the input register without entering the buffer. i_rst_n clears the
// pipe and loads the register defaults; o_byte stalls hold the buffer and,
// once the input register also holds a point that gives bytes, drop i_cp.ready.
`default_nettype none

`include "utf32_to_utf8_encoder_macros.svh"

module utf32_to_utf8_encoder (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    u8enc_cp_if.sink     i_cp,
    u8enc_byte_if.source o_byte,
    u8enc_cfg_if.sink    i_cfg
);

    localparam int CPW = u8enc_pkg::CP_W;
    localparam int BW  = u8enc_pkg::BYTE_W;

    // configuration registers
    logic [CPW-1:0]                 r_base;
    logic [u8enc_pkg::MAX_CP_W-1:0] r_max;

    // input register
    logic           r_in_vld;
    logic [CPW-1:0] r_cp;

    // byte buffer
    logic          r_buf_vld;
    logic [BW-1:0] r_bytes [4];
    logic [1:0]    r_lenm1;
    logic [1:0]    r_idx;
    logic          r_esc;

    // encoder outputs
    logic [CPW:0]  w_diff;
    logic          w_in_win;
    logic          w_empty;
    logic [BW-1:0] n_bytes [4];
    logic [1:0]    n_lenm1;

    // handshake terms
    logic w_out_take;
    logic w_last;
    logic w_buf_free;
    logic w_st1_go;
    logic w_in_take;
    logic w_cfg_take;

    // config writes, always accepted
    assign i_cfg.ready = 1'b1;
    assign w_cfg_take  = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= u8enc_pkg::ESCAPE_BASE_RST;
            r_max  <= u8enc_pkg::MAX_CP_RST;
        end else if (w_cfg_take) begin
            case (i_cfg.index)
                u8enc_pkg::CFG_ESCAPE_BASE:    r_base <= i_cfg.data;
                u8enc_pkg::CFG_MAX_CODE_POINT: r_max  <= i_cfg.data[u8enc_pkg::MAX_CP_W-1:0];
                default:                       ;
            endcase
        end
    end

    // escape window test, clipped at the top of the 32-bit range
    assign w_diff   = {1'b0, r_cp} - {1'b0, r_base};
    assign w_in_win = !w_diff[CPW] && (w_diff[CPW-1:BW] == '0);

    // utf-8 encode of the registered point, or escape offset, or no byte
    always_comb begin
        n_bytes[0] = r_cp[BW-1:0];
        n_bytes[1] = '0;
        n_bytes[2] = '0;
        n_bytes[3] = '0;
        n_lenm1    = 2'd0;
        w_empty    = 1'b0;
        if (w_in_win) begin
            n_bytes[0] = w_diff[BW-1:0];
        end else if (r_cp[CPW-1:7] == '0) begin
            n_bytes[0] = {1'b0, r_cp[6:0]};
        end else if (r_cp[CPW-1:11] == '0) begin
            n_bytes[0] = u8enc_pkg::LEAD2 | {3'b000, r_cp[10:6]};
            n_bytes[1] = u8enc_pkg::CONT_MARK | {2'b00, r_cp[5:0]};
            n_lenm1    = 2'd1;
        end else if (r_cp[CPW-1:16] == '0) begin
            n_bytes[0] = u8enc_pkg::LEAD3 | {4'b0000, r_cp[15:12]};
            n_bytes[1] = u8enc_pkg::CONT_MARK | {2'b00, r_cp[11:6]};
            n_bytes[2] = u8enc_pkg::CONT_MARK | {2'b00, r_cp[5:0]};
            n_lenm1    = 2'd2;
        end else if (r_cp <= {{(CPW - u8enc_pkg::MAX_CP_W){1'b0}}, r_max}) begin
            n_bytes[0] = u8enc_pkg::LEAD4 | {5'b00000, r_cp[20:18]};
            n_bytes[1] = u8enc_pkg::CONT_MARK | {2'b00, r_cp[17:12]};
            n_bytes[2] = u8enc_pkg::CONT_MARK | {2'b00, r_cp[11:6]};
            n_bytes[3] = u8enc_pkg::CONT_MARK | {2'b00, r_cp[5:0]};
            n_lenm1    = 2'd3;
        end else begin
            w_empty    = 1'b1;
        end
    end

    // pipeline flow control
    assign w_out_take = r_buf_vld && o_byte.ready;
    assign w_last     = (r_idx == r_lenm1);
    assign w_buf_free = !r_buf_vld || (w_out_take && w_last);
    assign w_st1_go   = r_in_vld && (w_empty || w_buf_free);
    assign i_cp.ready = !r_in_vld || w_st1_go;
    assign w_in_take  = i_cp.valid && i_cp.ready;

    // input register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_take) begin
            r_in_vld <= 1'b1;
        end else if (w_st1_go) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_cp <= i_cp.code_point;
        end
    end

    // byte buffer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_vld <= 1'b0;
            r_idx     <= 2'd0;
        end else if (w_st1_go && !w_empty) begin
            r_buf_vld <= 1'b1;
            r_idx     <= 2'd0;
        end else if (w_out_take) begin
            if (w_last) begin
                r_buf_vld <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // byte buffer payload
    always_ff @(posedge i_clk) begin
        if (w_st1_go && !w_empty) begin
            r_bytes <= n_bytes;
            r_lenm1 <= n_lenm1;
            r_esc   <= w_in_win;
        end
    end

    // result channel
    assign o_byte.valid       = r_buf_vld;
    assign o_byte.out_byte    = r_bytes[r_idx];
    assign o_byte.last_of_run = w_last;
    assign o_byte.is_escape   = r_esc;

    // checks
    `U8E_ASSERT_ALWAYS(a_rst_clears, i_clk, !i_rst_n |=> (!r_buf_vld && !r_in_vld))
    `U8E_ASSERT(a_idx_in_run, i_clk, i_rst_n, r_buf_vld |-> (r_idx <= r_lenm1))
    `U8E_ASSERT(a_esc_single, i_clk, i_rst_n, (r_buf_vld && r_esc) |-> (r_lenm1 == 2'd0))
    `U8E_ASSERT(a_run_continues, i_clk, i_rst_n, (w_out_take && !w_last) |=> (r_buf_vld && (r_idx == $past(r_idx) + 2'd1)))

endmodule

`default_nettype wire
